### src/tbda_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and twiddle table of the two-bin DFT accumulator.
package tbda_pkg;

   localparam int CMD_W      = 2;
   localparam int SAMPLE_W   = 13;
   localparam int INDEX_W    = 4;
   localparam int TWID_W     = 12;
   localparam int PROD_W     = SAMPLE_W + TWID_W;
   localparam int SUM_W      = 32;
   localparam int SCALE_SH   = 10;
   localparam int QUOT_W     = SUM_W - SCALE_SH;
   localparam int SQ_W       = 2 * QUOT_W;
   localparam int MAG_W      = 34;
   localparam int FRAME_LEN  = 16;

   typedef enum logic [CMD_W-1:0] {
      CMD_ACCUM    = 2'd0,
      CMD_READ_ONE = 2'd1,
      CMD_READ_TWO = 2'd2,
      CMD_CLEAR    = 2'd3
   } cmd_type;

   // per-bin controls from the command decode
   typedef struct packed {
      logic mac_en;
      logic clear_en;
   } bin_ctrl_type;

   // cosine over one frame, scaled by 1024
   localparam logic signed [TWID_W-1:0] COS_TAB [FRAME_LEN] = '{
      12'sd1024, 12'sd946, 12'sd724, 12'sd392, 12'sd0, -12'sd392, -12'sd724, -12'sd946,
      -12'sd1024, -12'sd946, -12'sd724, -12'sd392, 12'sd0, 12'sd392, 12'sd724, 12'sd946
   };

   function automatic logic signed [TWID_W-1:0] cos_twiddle(input logic [INDEX_W-1:0] k);
      return COS_TAB[k];
   endfunction

   // -sin(k) equals cos(k + quarter frame)
   function automatic logic signed [TWID_W-1:0] nsin_twiddle(input logic [INDEX_W-1:0] k);
      logic [INDEX_W-1:0] kq;
      kq = k + INDEX_W'(FRAME_LEN / 4);
      return COS_TAB[kq];
   endfunction

endpackage

### src/tbda_bin.sv
`timescale 1ns / 1ps
// One frequency bin: real and imaginary sums, multiply-accumulate and magnitude.
module tbda_bin (
   input  logic                                clock,
   input  logic                                reset,
   input  tbda_pkg::bin_ctrl_type              ctrl,
   input  logic signed [tbda_pkg::SAMPLE_W-1:0] sample,
   input  logic [tbda_pkg::INDEX_W-1:0]        twiddle_index,
   output logic [tbda_pkg::MAG_W-1:0]          magnitude_sq
);
   import tbda_pkg::*;

   logic signed [SUM_W-1:0]  real_sum_ff, real_sum_in;
   logic signed [SUM_W-1:0]  imag_sum_ff, imag_sum_in;
   logic signed [PROD_W-1:0] real_prod, imag_prod;
   logic signed [SUM_W-1:0]  real_bias, imag_bias;
   logic [QUOT_W-1:0]        real_quot, imag_quot;
   logic [QUOT_W-1:0]        real_abs, imag_abs;
   logic [SQ_W-1:0]          real_sq, imag_sq;
   logic [SQ_W:0]            mag_full;

   // multiply sample by twiddles
   assign real_prod = sample * cos_twiddle(twiddle_index);
   assign imag_prod = sample * nsin_twiddle(twiddle_index);

   // advance sums: clear wins, otherwise accumulate with wrap
   always_comb begin
      real_sum_in = real_sum_ff;
      imag_sum_in = imag_sum_ff;
      if (ctrl.clear_en) begin
         real_sum_in = '0;
         imag_sum_in = '0;
      end else if (ctrl.mac_en) begin
         real_sum_in = real_sum_ff + SUM_W'(real_prod);
         imag_sum_in = imag_sum_ff + SUM_W'(imag_prod);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         real_sum_ff <= '0;
         imag_sum_ff <= '0;
      end else begin
         real_sum_ff <= real_sum_in;
         imag_sum_ff <= imag_sum_in;
      end
   end

   // divide by 1024 toward zero: bias negatives before the shift
   assign real_bias = real_sum_ff + (real_sum_ff[SUM_W-1] ?
                      SUM_W'((1 << SCALE_SH) - 1) : SUM_W'(0));
   assign imag_bias = imag_sum_ff + (imag_sum_ff[SUM_W-1] ?
                      SUM_W'((1 << SCALE_SH) - 1) : SUM_W'(0));
   assign real_quot = real_bias[SUM_W-1:SCALE_SH];
   assign imag_quot = imag_bias[SUM_W-1:SCALE_SH];

   // magnitude of each part; the most negative quotient maps to 2^21
   assign real_abs = real_quot[QUOT_W-1] ? (~real_quot + QUOT_W'(1)) : real_quot;
   assign imag_abs = imag_quot[QUOT_W-1] ? (~imag_quot + QUOT_W'(1)) : imag_quot;

   // sum of squares, saturated to the result width
   assign real_sq  = real_abs * real_abs;
   assign imag_sq  = imag_abs * imag_abs;
   assign mag_full = {1'b0, real_sq} + {1'b0, imag_sq};
   assign magnitude_sq = (|mag_full[SQ_W:MAG_W]) ? {MAG_W{1'b1}} : mag_full[MAG_W-1:0];

endmodule

### src/two_bin_dft_accumulator.sv
`timescale 1ns / 1ps
// Top level of the two-bin DFT accumulator.
// A read item passes from the input register to the result register.
// Throughput: one item per cycle; the input register takes a new item while
// the result register still holds a result, and stalls only while a read waits
// in the input register behind a stalled result.
// Reset (synchronous, active high) zeroes all four sums and empties both registers.
module two_bin_dft_accumulator (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [tbda_pkg::CMD_W-1:0]           req_cmd,
   input  logic signed [tbda_pkg::SAMPLE_W-1:0] req_sample,
   input  logic [tbda_pkg::INDEX_W-1:0]         req_sample_index,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_bin_select,
   output logic [tbda_pkg::MAG_W-1:0]           rsp_magnitude_sq
);
   import tbda_pkg::*;

   logic                       s1_valid_ff;
   cmd_type                    s1_cmd_ff;
   logic signed [SAMPLE_W-1:0] s1_sample_ff;
   logic [INDEX_W-1:0]         s1_index_ff;
   logic [INDEX_W-1:0]         s1_index_two;
   logic                       s1_is_read;
   logic                       out_free;
   logic                       s1_advance;
   logic                       s1_fire;
   logic                       req_take;
   bin_ctrl_type               ctrl_one, ctrl_two;
   logic [MAG_W-1:0]           mag_one, mag_two;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_bin_ff;
   logic [MAG_W-1:0]           rsp_mag_ff;

   // handshake between the two registers
   assign s1_is_read = (s1_cmd_ff == CMD_READ_ONE) || (s1_cmd_ff == CMD_READ_TWO);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign s1_advance = !s1_is_read || out_free;
   assign s1_fire    = s1_valid_ff && s1_advance;
   assign req_stall  = s1_valid_ff && !s1_advance;
   assign req_take   = req_valid && !req_stall;

   // hold the accepted item in the input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         s1_valid_ff <= req_valid;
      end
      if (req_take) begin
         s1_cmd_ff    <= cmd_type'(req_cmd);
         s1_sample_ff <= req_sample;
         s1_index_ff  <= req_sample_index;
      end
   end

   // decode the command into per-bin controls
   always_comb begin
      ctrl_one = '0;
      ctrl_two = '0;
      if (s1_fire) begin
         case (s1_cmd_ff)
            CMD_ACCUM: begin
               ctrl_one.mac_en = 1'b1;
               ctrl_two.mac_en = 1'b1;
            end
            CMD_READ_ONE: ctrl_one.clear_en = 1'b1;
            CMD_READ_TWO: ctrl_two.clear_en = 1'b1;
            CMD_CLEAR: begin
               ctrl_one.clear_en = 1'b1;
               ctrl_two.clear_en = 1'b1;
            end
            default: begin
               ctrl_one = '0;
               ctrl_two = '0;
            end
         endcase
      end
   end

   // second bin steps twice as fast around the frame
   assign s1_index_two = {s1_index_ff[INDEX_W-2:0], 1'b0};

   tbda_bin u_bin_one (
      .clock         (clock),
      .reset         (reset),
      .ctrl          (ctrl_one),
      .sample        (s1_sample_ff),
      .twiddle_index (s1_index_ff),
      .magnitude_sq  (mag_one)
   );

   tbda_bin u_bin_two (
      .clock         (clock),
      .reset         (reset),
      .ctrl          (ctrl_two),
      .sample        (s1_sample_ff),
      .twiddle_index (s1_index_two),
      .magnitude_sq  (mag_two)
   );

   // load the result register on a read, drop it once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (s1_fire && s1_is_read) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (s1_fire && s1_is_read) begin
         rsp_bin_ff <= (s1_cmd_ff == CMD_READ_TWO);
         rsp_mag_ff <= (s1_cmd_ff == CMD_READ_TWO) ? mag_two : mag_one;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_bin_select   = rsp_bin_ff;
   assign rsp_magnitude_sq = rsp_mag_ff;

endmodule

### src/two_bin_dft_accumulator_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the two-bin DFT accumulator, bound to the top level.
module two_bin_dft_accumulator_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_stall,
   input logic [tbda_pkg::CMD_W-1:0]           req_cmd,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input logic                                 rsp_bin_select,
   input logic [tbda_pkg::MAG_W-1:0]           rsp_magnitude_sq
);
   import tbda_pkg::*;

   // leave reset empty and ready
   assert property (@(posedge clock) reset |=> !rsp_valid && !req_stall)
      else $error("not empty after reset");

   // input stalls only when the result side is full and blocked
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without output back-pressure");

   // a new result comes from an accepted read, for that bin
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |->
         $past(req_valid && !req_stall &&
               (req_cmd == CMD_READ_ONE || req_cmd == CMD_READ_TWO), 2) &&
         (rsp_bin_select == $past(req_cmd == CMD_READ_TWO, 2)))
      else $error("result without matching read");

   // hold a stalled result
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=>
         rsp_valid && $stable(rsp_bin_select) && $stable(rsp_magnitude_sq))
      else $error("stalled result changed");

endmodule

bind two_bin_dft_accumulator two_bin_dft_accumulator_checker u_checker (.*);
